### hw/rtl/cidh_pkg.sv
// Shared types and constants for the CAN identifier hash table.
package cidh_pkg;

  localparam int unsigned KEY_W = 30;
  localparam int unsigned ID_W = 29;
  localparam int unsigned REF_W = 8;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_HIT       = 3'd3;
  localparam logic [2:0] ST_MISS      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef struct packed {
    logic [1:0]       mode;
    logic [ID_W-1:0]  message_id;
    logic             extended_frame;
    logic [REF_W-1:0] entry_ref;
  } cidh_cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [REF_W-1:0] found_ref;
  } cidh_result_t;

endpackage

### hw/rtl/can_id_hash_lookup_table.sv
// Insert or lookup passes through S_HASH, then S_REDUCE for modulo reduction when TABLE_SLOTS
// is not a power of two, then S_READ and S_CMP for each probe before done is raised.
// Clear sweeps every used flag before done is raised; an unused mode answers from S_HASH with a miss.
// Only one transaction is taken at a time; each probe takes a memory read state and a compare state.
// Reset runs a pass over every used flag with busy high; no result is given.
// The receiver cannot stall: done is a one-cycle strobe and busy drops in that same cycle.
module can_id_hash_lookup_table
  import cidh_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  cidh_cmd_t    cmd,
  output logic         done,
  output cidh_result_t result
);

  localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
  localparam int unsigned DATA_W = KEY_W + REF_W;
  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [SLOT_W:0] SLOTS_W1 = (SLOT_W + 1)'(TABLE_SLOTS);
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / TABLE_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_HASH   = 6'b000010,
    S_REDUCE = 6'b000100,
    S_READ   = 6'b001000,
    S_CMP    = 6'b010000,
    S_CLEAR  = 6'b100000
  } state_t;

  state_t state;

  logic [1:0]        mode;
  logic [KEY_W-1:0]  key;
  logic [REF_W-1:0]  ref_in;
  logic [31:0]       prod;
  logic [31:0]       quot;
  logic              reduce_phase;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W:0]   probes;
  logic [SLOT_W-1:0] clr_idx;
  logic              clr_report;

  logic              slot_used [TABLE_SLOTS];
  logic [DATA_W-1:0] slot_data [TABLE_SLOTS];
  logic              used_q;
  logic [DATA_W-1:0] data_q;

  logic              used_we;
  logic              used_wd;
  logic [SLOT_W-1:0] used_addr;
  logic              data_we;
  logic [31:0]       hash_full;
  logic [63:0]       recip_prod;
  logic [SLOT_W:0]   qn_low;
  logic [SLOT_W:0]   rem_est;
  logic [SLOT_W-1:0] rem_next;
  logic              key_match;
  logic [SLOT_W:0]   probes_next;
  logic [SLOT_W-1:0] slot_next;

  assign busy = (state != S_IDLE);

  assign hash_full   = 32'(32'(key) * HASH_MULT);
  // The reciprocal estimate of the quotient is low by at most one, so the
  // remainder estimate is below twice the table size and one subtract fixes it.
  assign recip_prod  = 64'(prod) * 64'(RECIP);
  assign qn_low      = (SLOT_W + 1)'(quot[SLOT_W:0] * SLOTS_W1);
  assign rem_est     = prod[SLOT_W:0] - qn_low;
  assign rem_next    = (rem_est >= SLOTS_W1) ? SLOT_W'(rem_est - SLOTS_W1) : rem_est[SLOT_W-1:0];
  assign key_match   = (data_q[DATA_W-1:REF_W] == key);
  assign probes_next = probes + 1'b1;
  assign slot_next   = (slot == LAST_SLOT) ? '0 : slot + 1'b1;

  // Write port control: the clear sweep owns the used flags, a free slot takes the insert.
  always_comb begin
    used_we   = 1'b0;
    used_wd   = 1'b0;
    used_addr = slot;
    data_we   = 1'b0;
    if (state == S_CLEAR) begin
      used_we   = 1'b1;
      used_addr = clr_idx;
    end else if (state == S_CMP && mode == MODE_INSERT && !used_q) begin
      used_we = 1'b1;
      used_wd = 1'b1;
      data_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) begin
      slot_used[used_addr] <= used_wd;
    end
    used_q <= slot_used[slot];
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      slot_data[slot] <= {key, ref_in};
    end
    data_q <= slot_data[slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      slot       <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            mode   <= cmd.mode;
            key    <= {cmd.extended_frame, cmd.message_id};
            ref_in <= cmd.entry_ref;
            state  <= S_HASH;
          end
        end
        S_HASH: begin
          prod         <= hash_full;
          reduce_phase <= 1'b0;
          probes       <= '0;
          if (mode == MODE_INSERT || mode == MODE_LOOKUP) begin
            if (IS_POW2) begin
              slot  <= hash_full[SLOT_W-1:0];
              state <= S_READ;
            end else begin
              state <= S_REDUCE;
            end
          end else if (mode == MODE_CLEAR) begin
            clr_idx    <= '0;
            clr_report <= 1'b1;
            state      <= S_CLEAR;
          end else begin
            result.status    <= ST_MISS;
            result.found_ref <= '0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_REDUCE: begin
          if (!reduce_phase) begin
            quot         <= recip_prod[63:32];
            reduce_phase <= 1'b1;
          end else begin
            slot  <= rem_next;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          probes <= probes_next;
          if (!used_q) begin
            result.status    <= (mode == MODE_INSERT) ? ST_INSERTED : ST_MISS;
            result.found_ref <= '0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else if (key_match) begin
            result.status    <= (mode == MODE_INSERT) ? ST_DUPLICATE : ST_HIT;
            result.found_ref <= (mode == MODE_INSERT) ? '0 : data_q[REF_W-1:0];
            done             <= 1'b1;
            state            <= S_IDLE;
          end else if (probes_next == SLOTS_W1) begin
            result.status    <= (mode == MODE_INSERT) ? ST_FULL : ST_MISS;
            result.found_ref <= '0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else begin
            slot  <= slot_next;
            state <= S_READ;
          end
        end
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SLOT) begin
            if (clr_report) begin
              result.status    <= ST_CLEARED;
              result.found_ref <= '0;
              done             <= 1'b1;
            end
            clr_report <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  a_probe_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |-> (probes < SLOTS_W1))
    else $error("probe count ran past the table size");

  a_ref_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ST_HIT) |-> (result.found_ref == '0))
    else $error("nonzero found_ref on a result that is not a hit");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status <= ST_CLEARED))
    else $error("status code out of range");

endmodule

### bench/testbench.sv
// Self-checking testbench for the CAN identifier hash table: directed and random commands.
module testbench;
  import cidh_pkg::*;

  localparam int unsigned NUM_SLOTS = 256;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned STALL_LIMIT = 8 * (2 * NUM_SLOTS + 2);
  localparam int unsigned MAX_PRINTED = 60;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    cidh_cmd_t   cmd;
    int unsigned idle_pct;
  } pending_cmd_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  cidh_cmd_t    cmd = '0;
  logic         busy;
  logic         done;
  cidh_result_t result;

  pending_cmd_t pending_cmds[$];
  cidh_result_t expected_responses[$];

  // Shadow copy of the table contents.
  bit           model_used[NUM_SLOTS];
  logic [29:0]  model_key[NUM_SLOTS];
  logic [7:0]   model_ref[NUM_SLOTS];

  // Keys registered by the stimulus since its last clear.
  logic [29:0]  gen_keys[$];
  bit           gen_seen[logic [29:0]];

  int unsigned  mismatch_count = 0;
  int unsigned  accepted_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  status_tally[8];
  int unsigned  stall_cycles = 0;

  can_id_hash_lookup_table #(.TABLE_SLOTS(NUM_SLOTS)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  always #4 clk = ~clk;

  function automatic int unsigned home_slot(logic [29:0] key);
    logic [31:0] prod;
    prod = key * HASH_MULT;
    return prod % NUM_SLOTS;
  endfunction

  function automatic cidh_result_t hash_table_response(cidh_cmd_t c);
    cidh_result_t res;
    logic [29:0]  key;
    int unsigned  s;
    key = {c.extended_frame, c.message_id};
    res.status = ST_MISS;
    res.found_ref = '0;
    s = home_slot(key);
    case (c.mode)
      MODE_INSERT: begin
        res.status = ST_FULL;
        for (int p = 0; p < NUM_SLOTS; p++) begin
          if (!model_used[s]) begin
            model_used[s] = 1'b1;
            model_key[s] = key;
            model_ref[s] = c.entry_ref;
            res.status = ST_INSERTED;
            break;
          end
          if (model_key[s] == key) begin
            res.status = ST_DUPLICATE;
            break;
          end
          s = (s + 1) % NUM_SLOTS;
        end
      end
      MODE_LOOKUP: begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
          if (!model_used[s]) break;
          if (model_key[s] == key) begin
            res.status = ST_HIT;
            res.found_ref = model_ref[s];
            break;
          end
          s = (s + 1) % NUM_SLOTS;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < NUM_SLOTS; i++) model_used[i] = 1'b0;
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH: %s", msg);
  endtask

  // Sender idling changes in phases of 150 commands: none, heavy, light.
  task automatic queue_cmd(logic [1:0] m, logic [29:0] key, logic [7:0] entry);
    pending_cmd_t pc;
    int unsigned  idle_by_phase[3];
    idle_by_phase = '{0, 79, 9};
    pc.cmd.mode = m;
    pc.cmd.message_id = key[28:0];
    pc.cmd.extended_frame = key[29];
    pc.cmd.entry_ref = entry;
    pc.idle_pct = idle_by_phase[(pending_cmds.size() / 150) % 3];
    pending_cmds.push_back(pc);
  endtask

  function automatic logic [29:0] any_key();
    return 30'($urandom);
  endfunction

  // New keys are fully random, standard 11-bit ids, or members of a family
  // that share one home slot and so build probe chains.
  function automatic logic [29:0] fresh_key(int unsigned fam);
    case ($urandom_range(0, 2))
      0: return any_key();
      1: return {1'b0, 18'd0, 11'($urandom)};
      default: return {1'($urandom), 29'(fam + 256 * $urandom_range(0, 15))};
    endcase
  endfunction

  task automatic note_key(logic [29:0] key);
    if (!gen_seen.exists(key)) begin
      gen_seen[key] = 1'b1;
      gen_keys.push_back(key);
    end
  endtask

  task automatic queue_clear();
    queue_cmd(MODE_CLEAR, any_key(), 8'($urandom));
    gen_keys.delete();
    gen_seen.delete();
  endtask

  function automatic logic [29:0] stored_key();
    return gen_keys[$urandom_range(0, gen_keys.size() - 1)];
  endfunction

  task automatic gen_session(int unsigned n_ops);
    int unsigned fam;
    int unsigned r;
    logic [29:0] k;
    fam = $urandom_range(0, NUM_SLOTS - 1);
    queue_clear();
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (r < 45 || gen_keys.size() == 0) begin
        k = fresh_key(fam);
        queue_cmd(MODE_INSERT, k, 8'($urandom));
        note_key(k);
      end else if (r < 55) begin
        queue_cmd(MODE_INSERT, stored_key(), 8'($urandom));
      end else if (r < 85) begin
        queue_cmd(MODE_LOOKUP, stored_key(), 8'($urandom));
      end else if (r < 96) begin
        queue_cmd(MODE_LOOKUP, fresh_key(fam), 8'($urandom));
      end else begin
        queue_cmd(MODE_UNUSED, any_key(), 8'($urandom));
      end
    end
  endtask

  // Fills every slot, then drives inserts, lookups and one unused-mode command against the full table.
  // With spread set the keys land on distinct home slots.
  task automatic gen_fill(bit spread);
    int unsigned n;
    logic [29:0] k;
    queue_clear();
    n = 0;
    while (gen_seen.num() < NUM_SLOTS) begin
      if (spread) k = {1'($urandom), 21'($urandom), 8'((n * 37) % NUM_SLOTS)};
      else k = any_key();
      n++;
      queue_cmd(MODE_INSERT, k, 8'($urandom));
      note_key(k);
      if ($urandom_range(0, 4) == 0) queue_cmd(MODE_LOOKUP, stored_key(), 8'($urandom));
    end
    repeat (4) queue_cmd(MODE_INSERT, any_key(), 8'($urandom));
    repeat (3) queue_cmd(MODE_INSERT, stored_key(), 8'($urandom));
    repeat (10) queue_cmd(MODE_LOOKUP, stored_key(), 8'($urandom));
    repeat (6) queue_cmd(MODE_LOOKUP, any_key(), 8'($urandom));
    queue_cmd(MODE_UNUSED, any_key(), 8'($urandom));
  endtask

  always @(posedge clk) begin : drive_proc
    logic accepted;
    cidh_result_t predicted;
    accepted = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (accepted) begin
        predicted = hash_table_response(cmd);
        status_tally[predicted.status]++;
        expected_responses.push_back(predicted);
        void'(pending_cmds.pop_front());
        accepted_count++;
      end
      // A command that is still waiting for acceptance is held as it is.
      if (!start || accepted) begin
        if (pending_cmds.size() != 0 &&
            $urandom_range(0, 99) >= pending_cmds[0].idle_pct) begin
          start <= 1'b1;
          cmd <= pending_cmds[0].cmd;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    cidh_result_t want;
    if (!rst && done) begin
      if (expected_responses.size() == 0) begin
        report_mismatch($sformatf("result status=%0d ref=%0d with no transaction outstanding",
                                  result.status, result.found_ref));
      end else begin
        want = expected_responses.pop_front();
        checked_count++;
        if (result.status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    checked_count, result.status, want.status));
        if (result.found_ref !== want.found_ref)
          report_mismatch($sformatf("result %0d: found_ref %0d, expected %0d",
                                    checked_count, result.found_ref, want.found_ref));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int unsigned wrap_id;
    int unsigned target;
    wrap_id = 0;
    for (int i = 0; i < NUM_SLOTS; i++)
      if (home_slot(30'(i)) == NUM_SLOTS - 1) wrap_id = i;

    // Directed part: extremes, every mode, duplicates, wraparound, clear.
    queue_cmd(MODE_LOOKUP, 30'h123, 8'h00);
    queue_cmd(MODE_INSERT, 30'h0, 8'h00);
    queue_cmd(MODE_INSERT, 30'h3FFF_FFFF, 8'hFF);
    queue_cmd(MODE_INSERT, 30'h0, 8'hAA);
    queue_cmd(MODE_LOOKUP, 30'h0, 8'h55);
    queue_cmd(MODE_LOOKUP, 30'h3FFF_FFFF, 8'h00);
    queue_cmd(MODE_LOOKUP, 30'h2000_0000, 8'h00);
    queue_cmd(MODE_LOOKUP, 30'h1FFF_FFFF, 8'h00);
    queue_cmd(MODE_UNUSED, 30'h3FFF_FFFF, 8'hFF);
    // A chain that starts in the last slot wraps past the key held in slot 0.
    queue_cmd(MODE_INSERT, 30'(wrap_id), 8'h11);
    queue_cmd(MODE_INSERT, 30'(wrap_id + 256), 8'h22);
    queue_cmd(MODE_INSERT, 30'(wrap_id + 512), 8'h33);
    queue_cmd(MODE_LOOKUP, 30'(wrap_id + 512), 8'h00);
    queue_cmd(MODE_LOOKUP, 30'(wrap_id + 768), 8'h00);
    queue_cmd(MODE_INSERT, 30'(wrap_id + 256), 8'h44);
    queue_cmd(MODE_CLEAR, 30'h0, 8'h00);
    queue_cmd(MODE_LOOKUP, 30'h0, 8'h00);
    queue_cmd(MODE_INSERT, 30'(wrap_id + 512), 8'h5A);
    queue_cmd(MODE_LOOKUP, 30'(wrap_id + 512), 8'h00);
    queue_cmd(MODE_LOOKUP, 30'(wrap_id), 8'h00);
    queue_cmd(MODE_UNUSED, 30'h0, 8'h00);
    queue_cmd(MODE_CLEAR, 30'h3FFF_FFFF, 8'hFF);

    target = pending_cmds.size() + RANDOM_ITEMS;
    while (pending_cmds.size() < target - 2 * RANDOM_ITEMS / 3)
      gen_session($urandom_range(4, 40));
    gen_fill(1'b0);
    while (pending_cmds.size() < target - RANDOM_ITEMS / 4)
      gen_session($urandom_range(4, 40));
    gen_fill(1'b1);
    while (pending_cmds.size() < target)
      gen_session($urandom_range(4, 40));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start) @(posedge clk);
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (2 * NUM_SLOTS + 8) @(posedge clk);

    $display("Covered %0d commands with %0d results checked and %0d mismatches.",
             accepted_count, checked_count, mismatch_count);
    $display("Statuses: inserted %0d, duplicate %0d, full %0d, hit %0d, miss %0d, cleared %0d.",
             status_tally[ST_INSERTED], status_tally[ST_DUPLICATE], status_tally[ST_FULL],
             status_tally[ST_HIT], status_tally[ST_MISS], status_tally[ST_CLEARED]);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
